[sv/arl_pkg.sv]
// Shared types and constants for the address range lookup unit.
`default_nettype none

package arl_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int ENTRY_IDX_W = 10;

    typedef logic [IDX_W-1:0]       t_idx;
    typedef logic [CNT_W-1:0]       t_cnt;
    typedef logic [ENTRY_IDX_W-1:0] t_entry_idx;
    typedef logic [ADDR_W-1:0]      t_addr;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FOUND = 2'd1,
        ST_MISS  = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_APPEND,
        S_SEARCH
    } t_state;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] addr_value;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  entry_index;
        logic [31:0] region_start;
        logic [31:0] region_length;
    } t_out_beat;

    typedef struct packed {
        t_addr start;
        t_addr length;
    } t_entry;

    typedef struct packed {
        logic   en;
        t_idx   addr;
        t_entry data;
    } t_mem_wr;

endpackage

`default_nettype wire

[sv/arl_table.sv]
// Region table memory: one write port, one read port with registered data.
`default_nettype none

module arl_table (
    input  wire logic              i_clk,
    input  wire arl_pkg::t_mem_wr  i_wr,
    input  wire arl_pkg::t_idx     i_rd_addr,
    output arl_pkg::t_entry        o_rd_data
);

    arl_pkg::t_entry r_mem [arl_pkg::TABLE_DEPTH];
    arl_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[sv/arl_ctrl.sv]
// Command sequencer: append writes, binary search probes and result register.
`default_nettype none

module arl_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire arl_pkg::t_in_beat   i_beat,
    output logic                     o_busy,
    output logic                     o_done,
    output arl_pkg::t_out_beat       o_result,
    output arl_pkg::t_mem_wr         o_wr,
    output arl_pkg::t_idx            o_rd_addr,
    input  wire arl_pkg::t_entry     i_rd_data
);

    arl_pkg::t_state    r_state, n_state;
    arl_pkg::t_cnt      r_count, n_count;
    logic               r_out_valid, n_out_valid;
    arl_pkg::t_out_beat r_out, n_out;
    arl_pkg::t_addr     r_last_start, n_last_start;
    arl_pkg::t_addr     r_key, n_key;
    arl_pkg::t_cnt      r_lo, n_lo;
    arl_pkg::t_cnt      r_hi, n_hi;
    arl_pkg::t_idx      r_mid, n_mid;

    arl_pkg::t_cnt      s_lo, s_hi, s_mid;
    arl_pkg::t_addr     s_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= arl_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out        <= n_out;
        r_last_start <= n_last_start;
        r_key        <= n_key;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_mid        <= n_mid;
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_out_valid  = 1'b0;
        n_out        = r_out;
        n_last_start = r_last_start;
        n_key        = r_key;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid        = r_mid;
        o_wr         = '0;
        o_rd_addr    = r_mid;
        s_lo         = r_lo;
        s_hi         = r_hi;
        s_mid        = '0;
        s_off        = r_key - i_rd_data.start;

        case (r_state)
            arl_pkg::S_IDLE: begin
                if (i_start) begin
                    n_key = i_beat.addr_value;
                    n_out = '0;
                    case (i_beat.cmd)
                        arl_pkg::CMD_CLEAR: begin
                            n_count     = '0;
                            n_out_valid = 1'b1;
                        end
                        arl_pkg::CMD_APPEND: begin
                            if (r_count == arl_pkg::t_cnt'(arl_pkg::TABLE_DEPTH)) begin
                                n_out_valid = 1'b1;
                                n_out.status = arl_pkg::ST_FULL;
                            end else begin
                                // close the previous region
                                o_wr.en          = (r_count != '0);
                                o_wr.addr        = arl_pkg::t_idx'(r_count - 1'b1);
                                o_wr.data.start  = r_last_start;
                                o_wr.data.length = i_beat.addr_value - r_last_start;
                                n_state          = arl_pkg::S_APPEND;
                            end
                        end
                        arl_pkg::CMD_LOOKUP: begin
                            if (r_count == '0) begin
                                n_out_valid  = 1'b1;
                                n_out.status = arl_pkg::ST_MISS;
                            end else begin
                                n_lo      = '0;
                                n_hi      = r_count - 1'b1;
                                s_mid     = (r_count - 1'b1) >> 1;
                                n_mid     = arl_pkg::t_idx'(s_mid);
                                o_rd_addr = arl_pkg::t_idx'(s_mid);
                                n_state   = arl_pkg::S_SEARCH;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end

            arl_pkg::S_APPEND: begin
                o_wr.en           = 1'b1;
                o_wr.addr         = arl_pkg::t_idx'(r_count);
                o_wr.data.start   = r_key;
                o_wr.data.length  = '0;
                n_count           = r_count + 1'b1;
                n_last_start      = r_key;
                n_out_valid       = 1'b1;
                n_out             = '0;
                n_out.status      = arl_pkg::ST_DONE;
                n_out.entry_index = arl_pkg::t_entry_idx'(r_count);
                n_state           = arl_pkg::S_IDLE;
            end

            arl_pkg::S_SEARCH: begin
                n_out = '0;
                if (r_key < i_rd_data.start) begin
                    if (r_mid == '0) begin
                        n_out_valid  = 1'b1;
                        n_out.status = arl_pkg::ST_MISS;
                        n_state      = arl_pkg::S_IDLE;
                    end else begin
                        s_hi = arl_pkg::t_cnt'(r_mid) - 1'b1;
                    end
                end else if (s_off < i_rd_data.length) begin
                    n_out_valid         = 1'b1;
                    n_out.status        = arl_pkg::ST_FOUND;
                    n_out.entry_index   = arl_pkg::t_entry_idx'(r_mid);
                    n_out.region_start  = i_rd_data.start;
                    n_out.region_length = i_rd_data.length;
                    n_state             = arl_pkg::S_IDLE;
                end else begin
                    s_lo = arl_pkg::t_cnt'(r_mid) + 1'b1;
                end

                if (n_state == arl_pkg::S_SEARCH) begin
                    n_lo = s_lo;
                    n_hi = s_hi;
                    if (s_lo <= s_hi) begin
                        s_mid     = s_lo + ((s_hi - s_lo) >> 1);
                        n_mid     = arl_pkg::t_idx'(s_mid);
                        o_rd_addr = arl_pkg::t_idx'(s_mid);
                    end else begin
                        n_out_valid  = 1'b1;
                        n_out.status = arl_pkg::ST_MISS;
                        n_state      = arl_pkg::S_IDLE;
                    end
                end
            end

            default: begin
                n_state = arl_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy   = (r_state != arl_pkg::S_IDLE);
    assign o_done   = r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

[sv/address_range_lookup_unit.sv]
// Top level of the address range lookup unit.
//
// A command beat is taken when start is high and busy is low; each beat gives
// exactly one result beat on o_result, flagged by o_done for one cycle, which
// the receiver must take then. Clear, unused commands, a full-table append and
// a lookup on an empty table report in the cycle after the beat and do not
// raise busy. An append writes the previous entry's length in the accept cycle
// and the new entry in the next. A lookup makes one binary-search probe per
// read of the table memory, whose read data is registered, and makes at most
// ceil(log2(entries + 1)) probes. The table needs no clearing pass after
// reset.
`default_nettype none

module address_range_lookup_unit (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    input  wire arl_pkg::t_in_beat   i_in_beat,
    output logic                     busy,
    output logic                     o_done,
    output arl_pkg::t_out_beat       o_result
);

    arl_pkg::t_mem_wr s_wr;
    arl_pkg::t_idx    s_rd_addr;
    arl_pkg::t_entry  s_rd_data;

    arl_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_beat    (i_in_beat),
        .o_busy    (busy),
        .o_done    (o_done),
        .o_result  (o_result),
        .o_wr      (s_wr),
        .o_rd_addr (s_rd_addr),
        .i_rd_data (s_rd_data)
    );

    arl_table u_table (
        .i_clk     (i_clk),
        .i_wr      (s_wr),
        .i_rd_addr (s_rd_addr),
        .o_rd_data (s_rd_data)
    );

`ifndef SYNTHESIS
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted beat neither in progress nor reported");

    a_found_nonzero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == arl_pkg::ST_FOUND) |-> (o_result.region_length != '0))
        else $error("found entry with zero length");

    a_miss_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status != arl_pkg::ST_FOUND)
            |-> (o_result.region_start == '0 && o_result.region_length == '0))
        else $error("non-hit result carries region data");

    a_no_write_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && $past(busy) && !$past(s_wr.en) && $past(busy, 2)) |-> !s_wr.en)
        else $error("table written during a lookup");
`endif

endmodule

`default_nettype wire
